@@ rtl/bsl_pkg.sv @@
// ---------------------------------------------------------------------------
// bsl_pkg: shared types and constants of the build script lexer
// Token kinds, scan modes, character codes, byte classes and queue sizing.
// ---------------------------------------------------------------------------
package bsl_pkg;

   localparam int KIND_BITS        = 4;
   localparam int QUEUE_DEPTH      = 4;
   localparam int QUEUE_PTR_BITS   = 2;
   localparam int QUEUE_COUNT_BITS = 3;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_COLON   = 4'd0,
      KIND_LBRACE  = 4'd1,
      KIND_RBRACE  = 4'd2,
      KIND_DOLLAR  = 4'd3,
      KIND_NEWLINE = 4'd4,
      KIND_COMMENT = 4'd5,
      KIND_IDENT   = 4'd6,
      KIND_NUMBER  = 4'd7,
      KIND_OTHER   = 4'd8
   } bsl_kind_type;

   // Kind of the token that is currently open, one-hot.
   typedef enum logic [3:0] {
      MODE_NONE    = 4'b0001,
      MODE_COMMENT = 4'b0010,
      MODE_IDENT   = 4'b0100,
      MODE_NUMBER  = 4'b1000
   } bsl_mode_type;

   // Control from the front end to the token queue.
   typedef struct packed {
      logic valid;
      logic two;
   } bsl_push_type;

   localparam logic [7:0] CHAR_NUL        = 8'h00;
   localparam logic [7:0] CHAR_LF         = 8'h0A;
   localparam logic [7:0] CHAR_CR         = 8'h0D;
   localparam logic [7:0] CHAR_HASH       = 8'h23;
   localparam logic [7:0] CHAR_DOLLAR     = 8'h24;
   localparam logic [7:0] CHAR_COLON      = 8'h3A;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_LBRACE     = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE     = 8'h7D;

   function automatic logic is_letter(input logic [7:0] b);
      return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= 8'h30) && (b <= 8'h39);
   endfunction

   function automatic logic is_word(input logic [7:0] b);
      return is_letter(b) || is_digit(b) || (b == CHAR_UNDERSCORE);
   endfunction

endpackage

@@ rtl/bsl_channels_if.sv @@
// ---------------------------------------------------------------------------
// bsl channel interfaces
// Valid/ready channels for source bytes in and token records out.
// ---------------------------------------------------------------------------
interface bsl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] source_byte;
   logic       end_of_text;

   modport source (output valid, source_byte, end_of_text, input ready);
   modport sink   (input valid, source_byte, end_of_text, output ready);
endinterface

interface bsl_rsp_if #(
   parameter int LINE_BITS   = 16,
   parameter int COLUMN_BITS = 16,
   parameter int LENGTH_BITS = 16
);
   logic                   valid;
   logic                   ready;
   logic [3:0]             token_kind;
   logic [LINE_BITS-1:0]   start_line;
   logic [COLUMN_BITS-1:0] start_column;
   logic [LENGTH_BITS-1:0] token_length;
   logic                   run_last;

   modport source (output valid, token_kind, start_line, start_column, token_length,
                   run_last, input ready);
   modport sink   (input valid, token_kind, start_line, start_column, token_length,
                   run_last, output ready);
endinterface

@@ rtl/bsl_front.sv @@
// ---------------------------------------------------------------------------
// bsl_front: byte scanner
// Classifies each source byte, tracks the open token and the text position,
// and hands zero, one or two finished token records to the queue.
// ---------------------------------------------------------------------------
module bsl_front import bsl_pkg::*; #(
   parameter int LINE_BITS   = 16,
   parameter int COLUMN_BITS = 16,
   parameter int LENGTH_BITS = 16,
   localparam int RES_BITS   = KIND_BITS + LINE_BITS + COLUMN_BITS + LENGTH_BITS + 1
) (
   input  logic                clock,
   input  logic                reset,
   bsl_req_if.sink             req_if,
   input  logic                queue_full,
   output bsl_push_type        push,
   output logic [RES_BITS-1:0] first_result,
   output logic [RES_BITS-1:0] second_result
);

   bsl_mode_type           mode_ff, mode_in;
   logic [LINE_BITS-1:0]   pend_line_ff, pend_line_in;
   logic [COLUMN_BITS-1:0] pend_col_ff, pend_col_in;
   logic [LENGTH_BITS-1:0] pend_len_ff, pend_len_in;
   logic [LINE_BITS-1:0]   cur_line_ff, cur_line_in;
   logic [COLUMN_BITS-1:0] cur_col_ff, cur_col_in;

   logic                   accept;
   logic [7:0]             b;
   logic                   eot;
   logic [LINE_BITS-1:0]   adv_line;
   logic [COLUMN_BITS-1:0] adv_col;
   logic                   cont;
   logic                   start_word;
   logic [LENGTH_BITS-1:0] len_inc;
   logic [LENGTH_BITS-1:0] a_len;
   logic                   a_last;
   logic                   emit_a;
   logic                   emit_b;
   bsl_kind_type           pend_kind;
   bsl_kind_type           single_kind;
   bsl_kind_type           word_kind;
   bsl_kind_type           b_kind;
   bsl_mode_type           word_mode;
   logic [RES_BITS-1:0]    result_a;
   logic [RES_BITS-1:0]    result_b;

   assign req_if.ready = !queue_full;
   assign accept       = req_if.valid && req_if.ready;
   assign b            = req_if.source_byte;
   assign eot          = req_if.end_of_text;

   always_comb begin
      // Position after this byte; LF moves to the next line.
      adv_line = cur_line_ff;
      adv_col  = cur_col_ff;
      if (b == CHAR_LF) begin
         if (cur_line_ff != '1) adv_line = cur_line_ff + 1'b1;
         adv_col = COLUMN_BITS'(1);
      end else if ((b != CHAR_NUL) && !b[7]) begin
         if (cur_col_ff != '1) adv_col = cur_col_ff + 1'b1;
      end

      unique case (mode_ff)
         MODE_COMMENT: pend_kind = KIND_COMMENT;
         MODE_IDENT:   pend_kind = KIND_IDENT;
         default:      pend_kind = KIND_NUMBER;
      endcase

      unique case (b)
         CHAR_COLON:  single_kind = KIND_COLON;
         CHAR_LBRACE: single_kind = KIND_LBRACE;
         CHAR_RBRACE: single_kind = KIND_RBRACE;
         CHAR_DOLLAR: single_kind = KIND_DOLLAR;
         CHAR_LF:     single_kind = KIND_NEWLINE;
         default:     single_kind = KIND_OTHER;
      endcase

      if (b == CHAR_HASH) begin
         word_kind = KIND_COMMENT;
         word_mode = MODE_COMMENT;
      end else if (is_digit(b)) begin
         word_kind = KIND_NUMBER;
         word_mode = MODE_NUMBER;
      end else begin
         word_kind = KIND_IDENT;
         word_mode = MODE_IDENT;
      end

      cont       = (mode_ff == MODE_COMMENT) ? ((b != CHAR_CR) && (b != CHAR_LF))
                                             : is_word(b);
      start_word = (b == CHAR_HASH) || is_word(b);
      len_inc    = (pend_len_ff == '1) ? pend_len_ff : pend_len_ff + 1'b1;
      b_kind     = start_word ? word_kind : single_kind;

      emit_a      = 1'b0;
      emit_b      = 1'b0;
      a_last      = 1'b0;
      a_len       = pend_len_ff;
      mode_in     = mode_ff;
      pend_line_in = pend_line_ff;
      pend_col_in  = pend_col_ff;
      pend_len_in  = pend_len_ff;

      if ((mode_ff != MODE_NONE) && cont) begin
         // The byte extends the open token.
         pend_len_in = len_inc;
         a_len       = len_inc;
         if (eot) begin
            emit_a      = 1'b1;
            a_last      = 1'b1;
            mode_in     = MODE_NONE;
            pend_len_in = '0;
         end
      end else begin
         // Any open token ends here, then the byte starts a new token.
         emit_a       = (mode_ff != MODE_NONE);
         pend_line_in = cur_line_ff;
         pend_col_in  = cur_col_ff;
         pend_len_in  = LENGTH_BITS'(1);
         mode_in      = MODE_NONE;
         if (start_word && !eot) begin
            mode_in = word_mode;
         end else begin
            emit_b      = 1'b1;
            pend_len_in = '0;
         end
      end

      cur_line_in = eot ? LINE_BITS'(1) : adv_line;
      cur_col_in  = eot ? COLUMN_BITS'(1) : adv_col;

      result_a = {pend_kind, pend_line_ff, pend_col_ff, a_len, a_last};
      result_b = {b_kind, cur_line_ff, cur_col_ff, LENGTH_BITS'(1), 1'b1};
   end

   assign push.valid    = accept && (emit_a || emit_b);
   assign push.two      = emit_a && emit_b;
   assign first_result  = emit_a ? result_a : result_b;
   assign second_result = result_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_NONE;
         pend_line_ff <= LINE_BITS'(1);
         pend_col_ff  <= COLUMN_BITS'(1);
         pend_len_ff  <= '0;
         cur_line_ff  <= LINE_BITS'(1);
         cur_col_ff   <= COLUMN_BITS'(1);
      end else if (accept) begin
         mode_ff      <= mode_in;
         pend_line_ff <= pend_line_in;
         pend_col_ff  <= pend_col_in;
         pend_len_ff  <= pend_len_in;
         cur_line_ff  <= cur_line_in;
         cur_col_ff   <= cur_col_in;
      end
   end

endmodule

@@ rtl/bsl_queue.sv @@
// ---------------------------------------------------------------------------
// bsl_queue: token queue
// Short FIFO of per-byte entries, each holding one or two token records.
// ---------------------------------------------------------------------------
module bsl_queue import bsl_pkg::*; #(
   parameter int ENTRY_BITS = 107
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bsl_push_type          push,
   input  logic [ENTRY_BITS-1:0] push_data,
   input  logic                  pop,
   output logic                  head_valid,
   output logic [ENTRY_BITS-1:0] head_data,
   output logic                  full
);

   logic [ENTRY_BITS-1:0]       entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_BITS-1:0] count_ff, count_in;

   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == QUEUE_COUNT_BITS'(QUEUE_DEPTH));
   assign head_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push.valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid && !pop) count_in = count_ff + 1'b1;
      else if (!push.valid && pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // The fill level never exceeds the queue depth.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_COUNT_BITS'(QUEUE_DEPTH))
      else $error("token queue overfilled");

   // The front end never writes into a full queue.
   assert property (@(posedge clock) disable iff (reset) !(push.valid && full))
      else $error("push into full token queue");

   // The back end never pops an empty queue.
   assert property (@(posedge clock) disable iff (reset) !(pop && !head_valid))
      else $error("pop from empty token queue");

   // A push without a pop raises the fill level by one.
   assert property (@(posedge clock) disable iff (reset)
      (push.valid && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("token queue count did not follow a push");

endmodule

@@ rtl/bsl_back.sv @@
// ---------------------------------------------------------------------------
// bsl_back: token emitter
// Drains queue entries and presents their token records one beat at a time.
// ---------------------------------------------------------------------------
module bsl_back import bsl_pkg::*; #(
   parameter int LINE_BITS   = 16,
   parameter int COLUMN_BITS = 16,
   parameter int LENGTH_BITS = 16,
   localparam int RES_BITS   = KIND_BITS + LINE_BITS + COLUMN_BITS + LENGTH_BITS + 1,
   localparam int ENTRY_BITS = 2 * RES_BITS + 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  logic [ENTRY_BITS-1:0] head_data,
   output logic                  pop,
   bsl_rsp_if.source             rsp_if
);

   localparam int LEN_LO  = 1;
   localparam int COL_LO  = LEN_LO + LENGTH_BITS;
   localparam int LINE_LO = COL_LO + COLUMN_BITS;
   localparam int KIND_LO = LINE_LO + LINE_BITS;

   logic                sel_ff, sel_in;
   logic                head_two;
   logic                take;
   logic [RES_BITS-1:0] record;

   assign head_two = head_data[ENTRY_BITS-1];
   assign record   = sel_ff ? head_data[2*RES_BITS-1:RES_BITS] : head_data[RES_BITS-1:0];

   assign rsp_if.valid        = head_valid;
   assign rsp_if.token_kind   = record[KIND_LO +: KIND_BITS];
   assign rsp_if.start_line   = record[LINE_LO +: LINE_BITS];
   assign rsp_if.start_column = record[COL_LO +: COLUMN_BITS];
   assign rsp_if.token_length = record[LEN_LO +: LENGTH_BITS];
   assign rsp_if.run_last     = record[0];

   assign take   = rsp_if.valid && rsp_if.ready;
   assign pop    = take && (!head_two || sel_ff);
   assign sel_in = take ? (head_two && !sel_ff) : sel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= 1'b0;
      end else begin
         sel_ff <= sel_in;
      end
   end

   // The second record is selected only while a two-record entry is at the head.
   assert property (@(posedge clock) disable iff (reset) sel_ff |-> (head_valid && head_two))
      else $error("second record selected without a two-record entry");

endmodule

@@ rtl/build_script_lexer_unit.sv @@
// ---------------------------------------------------------------------------
// build_script_lexer_unit: streaming tokenizer for build script text
// Groups source bytes into tokens and reports kind, position and length.
// ---------------------------------------------------------------------------
// The unit takes one source byte per req_if beat and returns token records
// on rsp_if. Colon, braces, dollar and LF are one-byte tokens; a comment runs
// from '#' up to but not including CR or LF; identifiers and numbers continue
// over letters, digits and underscores; any other byte is a one-byte token of
// kind other. A token that spans several bytes is reported when the byte that
// ends it arrives, or at once when the byte marked end_of_text arrives, after
// which line and column return to 1 for the next text. A byte may produce no
// beat, one beat, or two beats (the closed token, then a one-byte token); the
// last beat caused by a byte carries run_last, except that a byte which closes
// a token and opens a new one yields a single beat with run_last low. Line,
// column and length saturate at their all-ones value. A byte is taken every
// cycle as long as the four-entry token queue between the scanner and the
// emitter has room; a byte's records are written into the queue as it is
// taken and reach rsp_if from its head. The result port drains one beat per
// cycle while rsp_if.ready is high, so two-beat bytes set the pace: a stream
// sustains one byte per cycle while it averages at most one beat per byte.
// ---------------------------------------------------------------------------
module build_script_lexer_unit import bsl_pkg::*; #(
   parameter int LINE_BITS   = 16,
   parameter int COLUMN_BITS = 16,
   parameter int LENGTH_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   bsl_req_if.sink   req_if,
   bsl_rsp_if.source rsp_if
);

   localparam int RES_BITS   = KIND_BITS + LINE_BITS + COLUMN_BITS + LENGTH_BITS + 1;
   localparam int ENTRY_BITS = 2 * RES_BITS + 1;

   bsl_push_type          push;
   logic [RES_BITS-1:0]   first_result;
   logic [RES_BITS-1:0]   second_result;
   logic                  queue_full;
   logic                  head_valid;
   logic [ENTRY_BITS-1:0] head_data;
   logic                  pop;

   // Front end: classifies each byte and keeps the open token and position.
   bsl_front #(
      .LINE_BITS   (LINE_BITS),
      .COLUMN_BITS (COLUMN_BITS),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_if        (req_if),
      .queue_full    (queue_full),
      .push          (push),
      .first_result  (first_result),
      .second_result (second_result)
   );

   // Each queue entry carries a flag for a second record, then both records.
   bsl_queue #(
      .ENTRY_BITS (ENTRY_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  ({push.two, second_result, first_result}),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data),
      .full       (queue_full)
   );

   // Back end: serializes each entry into one or two result beats.
   bsl_back #(
      .LINE_BITS   (LINE_BITS),
      .COLUMN_BITS (COLUMN_BITS),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_if     (rsp_if)
   );

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: regression for build_script_lexer_unit
// Feeds script text one byte per beat, predicts every token record in the
// bench and checks the records that come back, field by field, in order.
// ---------------------------------------------------------------------------
module testbench;
   import bsl_pkg::*;

   localparam int LINE_W      = 16;
   localparam int COLUMN_W    = 16;
   localparam int LENGTH_W    = 16;
   localparam int CYCLE_LIMIT = 2_000_000;

   typedef struct {
      logic [7:0] source_byte;
      logic       end_of_text;
   } source_beat_type;

   typedef struct {
      bsl_kind_type          kind;
      logic [LINE_W-1:0]     line;
      logic [COLUMN_W-1:0]   column;
      logic [LENGTH_W-1:0]   length;
      logic                  last;
   } token_rec_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bsl_req_if req_if ();
   bsl_rsp_if #(
      .LINE_BITS   (LINE_W),
      .COLUMN_BITS (COLUMN_W),
      .LENGTH_BITS (LENGTH_W)
   ) rsp_if ();

   build_script_lexer_unit #(
      .LINE_BITS   (LINE_W),
      .COLUMN_BITS (COLUMN_W),
      .LENGTH_BITS (LENGTH_W)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // 4 ns period: two delays, high then low.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Bytes waiting to be driven, and the token records still owed by the unit.
   source_beat_type source_q[$];
   token_rec_type   tokens_due[$];
   source_beat_type next_beat;

   int bytes_queued = 0;
   int bytes_taken  = 0;
   int error_count  = 0;
   int cycle_count  = 0;
   bit req_took     = 1'b0;

   // Idle chances in percent, changed by the sequencer between phases.
   int send_idle_pct = 34;
   int recv_idle_pct = 52;

   // -------------------------------------------------------------------------
   // Token predictor. It keeps its own copy of the scanner state: the token
   // that is still open (its kind, where it began and how long it is so far)
   // and the cursor position of the next byte.
   // -------------------------------------------------------------------------
   bsl_mode_type         scan_mode   = MODE_NONE;
   logic [LINE_W-1:0]    open_line   = 1;
   logic [COLUMN_W-1:0]  open_column = 1;
   logic [LENGTH_W-1:0]  open_length = 0;
   logic [LINE_W-1:0]    cur_line    = 1;
   logic [COLUMN_W-1:0]  cur_column  = 1;

   function automatic bit is_digit_char(input logic [7:0] b);
      return (b >= "0") && (b <= "9");
   endfunction

   // Letters, digits and underscore; this is also the set that opens a word.
   function automatic bit is_word_char(input logic [7:0] b);
      return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z")) ||
             is_digit_char(b) || (b == CHAR_UNDERSCORE);
   endfunction

   // LF moves to the next line and column 1. Printable and control bytes
   // below 128 step the column; NUL and the upper half leave it alone.
   function automatic void advance_cursor(input logic [7:0] b);
      if (b == CHAR_LF) begin
         if (cur_line != '1) cur_line++;
         cur_column = 1;
      end else if ((b >= 8'd1) && (b <= 8'd127)) begin
         if (cur_column != '1) cur_column++;
      end
   endfunction

   function automatic bsl_kind_type open_kind();
      case (scan_mode)
         MODE_COMMENT: return KIND_COMMENT;
         MODE_IDENT:   return KIND_IDENT;
         default:      return KIND_NUMBER;
      endcase
   endfunction

   function automatic void owe_token(input bsl_kind_type kind,
                                     input logic [LINE_W-1:0] line,
                                     input logic [COLUMN_W-1:0] column,
                                     input logic [LENGTH_W-1:0] length,
                                     input logic last);
      token_rec_type rec;
      rec.kind   = kind;
      rec.line   = line;
      rec.column = column;
      rec.length = length;
      rec.last   = last;
      tokens_due.push_back(rec);
   endfunction

   function automatic void scan_byte(input logic [7:0] b, input logic eot);
      bit           grows;
      bsl_kind_type single;
      if (scan_mode != MODE_NONE) begin
         if (scan_mode == MODE_COMMENT) grows = (b != CHAR_CR) && (b != CHAR_LF);
         else grows = is_word_char(b);
         if (grows) begin
            if (open_length != '1) open_length++;
            advance_cursor(b);
            if (eot) begin
               owe_token(open_kind(), open_line, open_column, open_length, 1'b1);
               scan_mode   = MODE_NONE;
               open_length = 0;
               cur_line    = 1;
               cur_column  = 1;
            end
            return;
         end
         // The byte ends the open token, which goes out first, and is then
         // scanned as the start of something new.
         owe_token(open_kind(), open_line, open_column, open_length, 1'b0);
         scan_mode   = MODE_NONE;
         open_length = 0;
      end
      if ((b == CHAR_HASH) || is_word_char(b)) begin
         if (b == CHAR_HASH) scan_mode = MODE_COMMENT;
         else if (is_digit_char(b)) scan_mode = MODE_NUMBER;
         else scan_mode = MODE_IDENT;
         open_line   = cur_line;
         open_column = cur_column;
         open_length = 1;
         advance_cursor(b);
         if (eot) begin
            owe_token(open_kind(), open_line, open_column, open_length, 1'b1);
            scan_mode   = MODE_NONE;
            open_length = 0;
         end
      end else begin
         case (b)
            CHAR_COLON:  single = KIND_COLON;
            CHAR_LBRACE: single = KIND_LBRACE;
            CHAR_RBRACE: single = KIND_RBRACE;
            CHAR_DOLLAR: single = KIND_DOLLAR;
            CHAR_LF:     single = KIND_NEWLINE;
            default:     single = KIND_OTHER;
         endcase
         owe_token(single, cur_line, cur_column, LENGTH_W'(1), 1'b1);
         advance_cursor(b);
      end
      // The next byte after the end of a text opens a fresh text.
      if (eot) begin
         cur_line   = 1;
         cur_column = 1;
      end
   endfunction

   // One line per mismatch, and every mismatch is counted.
   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      error_count++;
   endtask

   // -------------------------------------------------------------------------
   // Driver: everything changes at the falling edge. A byte stays on the
   // channel until the rising edge at which it is taken; only then may the
   // next byte, or an idle cycle, follow. Ready on the token side is redrawn
   // every cycle.
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         rsp_if.ready <= 1'b0;
      end else begin
         if (!req_if.valid || req_took) begin
            if ((source_q.size() != 0) && ($urandom_range(0, 99) >= send_idle_pct)) begin
               next_beat = source_q.pop_front();
               req_if.valid       <= 1'b1;
               req_if.source_byte <= next_beat.source_byte;
               req_if.end_of_text <= next_beat.end_of_text;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
         rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: at each rising edge a taken byte runs through the predictor and
   // a taken token record is compared with the oldest one owed. The byte is
   // handled first, although the unit never answers in the same cycle.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      req_took = 1'b0;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            req_took = 1'b1;
            scan_byte(req_if.source_byte, req_if.end_of_text);
            bytes_taken++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (tokens_due.size() == 0) begin
               report_mismatch($sformatf("token beat with none owed (kind %0d line %0d col %0d)",
                                         rsp_if.token_kind, rsp_if.start_line,
                                         rsp_if.start_column));
            end else begin
               token_rec_type want;
               want = tokens_due.pop_front();
               if (rsp_if.token_kind !== want.kind)
                  report_mismatch($sformatf("token_kind %0d, want %0d",
                                            rsp_if.token_kind, want.kind));
               if (rsp_if.start_line !== want.line)
                  report_mismatch($sformatf("start_line %0d, want %0d",
                                            rsp_if.start_line, want.line));
               if (rsp_if.start_column !== want.column)
                  report_mismatch($sformatf("start_column %0d, want %0d",
                                            rsp_if.start_column, want.column));
               if (rsp_if.token_length !== want.length)
                  report_mismatch($sformatf("token_length %0d, want %0d",
                                            rsp_if.token_length, want.length));
               if (rsp_if.run_last !== want.last)
                  report_mismatch($sformatf("run_last %0b, want %0b",
                                            rsp_if.run_last, want.last));
            end
         end
      end
   end

   // A hung unit still ends the run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("build_script_lexer_unit regression: fail");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   task automatic queue_byte(input logic [7:0] b, input logic eot);
      source_beat_type beat;
      beat.source_byte = b;
      beat.end_of_text = eot;
      source_q.push_back(beat);
      bytes_queued++;
   endtask

   // The last character carries end_of_text when close_text is set.
   task automatic queue_text(input string s, input bit close_text);
      for (int i = 0; i < s.len(); i++)
         queue_byte(s[i], close_text && (i == s.len() - 1));
   endtask

   // A letter, digit or underscore; no digit when it leads a word.
   function automatic logic [7:0] rand_word_char(input bit lead);
      int r;
      r = lead ? $urandom_range(0, 52) : $urandom_range(0, 62);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      if (r == 52) return CHAR_UNDERSCORE;
      return 8'("0" + r - 53);
   endfunction

   // Any byte that does not end a comment.
   function automatic logic [7:0] rand_comment_char();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while ((b == CHAR_CR) || (b == CHAR_LF));
      return b;
   endfunction

   // One text made mostly of well-formed script pieces glued together, with
   // stray whitespace, carriage returns and arbitrary bytes mixed in. Tokens
   // butt against each other often, so closing and reopening gets exercised.
   task automatic queue_random_text();
      logic [7:0] text[$];
      int         pieces;
      int         pick;
      int         len;
      pieces = $urandom_range(1, 24);
      for (int p = 0; p < pieces; p++) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            len = (pick < 2) ? $urandom_range(100, 300) : $urandom_range(0, 10);
            text.push_back(rand_word_char(1'b1));
            repeat (len) text.push_back(rand_word_char(1'b0));
         end else if (pick < 40) begin
            text.push_back(8'("0" + $urandom_range(0, 9)));
            repeat ($urandom_range(0, 6)) text.push_back(rand_word_char(1'b0));
         end else if (pick < 50) begin
            text.push_back(CHAR_HASH);
            repeat ($urandom_range(0, 20)) text.push_back(rand_comment_char());
         end else if (pick < 70) begin
            case ($urandom_range(0, 3))
               0:       text.push_back(CHAR_COLON);
               1:       text.push_back(CHAR_LBRACE);
               2:       text.push_back(CHAR_RBRACE);
               default: text.push_back(CHAR_DOLLAR);
            endcase
         end else if (pick < 80) begin
            text.push_back(CHAR_LF);
         end else if (pick < 85) begin
            text.push_back(CHAR_CR);
         end else if (pick < 93) begin
            text.push_back($urandom_range(0, 1) ? 8'h20 : 8'h09);
         end else begin
            text.push_back(8'($urandom_range(0, 255)));
         end
      end
      foreach (text[i]) queue_byte(text[i], i == text.size() - 1);
   endtask

   task automatic queue_random_phase(input int n_bytes);
      int target;
      target = bytes_queued + n_bytes;
      while (bytes_queued < target) queue_random_text();
   endtask

   // Wait at falling edges until every queued byte has been taken and every
   // owed token record has come back, then waits on for any stragglers.
   task automatic wait_drained();
      while ((bytes_taken != bytes_queued) || (tokens_due.size() != 0)) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Sequencer
   // -------------------------------------------------------------------------
   initial begin
      req_if.valid       = 1'b0;
      req_if.source_byte = 8'h00;
      req_if.end_of_text = 1'b0;
      rsp_if.ready       = 1'b0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: every single-byte kind, a comment cut by CR, words running
      // into numbers, NUL and upper-half bytes that do not move the column,
      // tokens open on the final byte of a text, and a byte that closes one
      // token and opens another right on the final byte.
      queue_text(":{}$\n#c\r", 1'b0);
      queue_text("aZ_9 0z_", 1'b0);
      queue_byte(CHAR_NUL, 1'b0);
      queue_byte(8'h7F, 1'b0);
      queue_byte(8'h80, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_text("q", 1'b1);
      queue_text("5", 1'b1);
      queue_text("x:", 1'b1);
      queue_text("y#", 1'b1);
      queue_text("#\n", 1'b1);

      // Sender idles 34%, receiver 52%.
      queue_random_phase(290);
      wait_drained();

      @(posedge clock);
      send_idle_pct = 52;
      recv_idle_pct = 34;
      queue_random_phase(290);
      wait_drained();

      // No idling at all.
      @(posedge clock);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random_phase(290);
      wait_drained();

      if (error_count == 0) begin
         $display("build_script_lexer_unit regression: pass");
      end else begin
         $display("build_script_lexer_unit regression: fail");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/bsl_pkg.sv
rtl/bsl_channels_if.sv
rtl/bsl_front.sv
rtl/bsl_queue.sv
rtl/bsl_back.sv
rtl/build_script_lexer_unit.sv
test/testbench.sv
